// File: src/brf_pkg.sv
// brf_pkg: shared types, request codes and constants for the byte ring FIFO.
// No dependencies; imported by brf_ram, byte_ring_fifo_8_16_core and the testbench.
package brf_pkg;

  localparam int DEPTH_DEF = 256;   // default store depth in bytes
  localparam int BYTE_W    = 8;
  localparam int SIZE_W    = 9;     // width of the size register and free count
  localparam int FUNC_W    = 4;
  localparam int DATA_W    = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // request codes
  localparam logic [FUNC_W-1:0] FN_WRITE8  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE16 = 4'd1;
  localparam logic [FUNC_W-1:0] FN_READ8   = 4'd2;
  localparam logic [FUNC_W-1:0] FN_READ16  = 4'd3;
  localparam logic [FUNC_W-1:0] FN_PEEK8   = 4'd4;
  localparam logic [FUNC_W-1:0] FN_PEEK16  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_GOTO    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 4'd7;
  localparam logic [FUNC_W-1:0] FN_FREE    = 4'd8;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] data;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic [SIZE_W-1:0] free_space;
  } out_t;

endpackage

// File: src/byte_ring_fifo_8_16_core.sv
// byte_ring_fifo_8_16_core: top level of the circular byte FIFO.
// Depends on brf_pkg (types, request codes) and brf_ram (byte store).
//
// Usage:
//   Request channel: present in_item (func, data) with start high; the
//   transaction is taken at a rising edge where start is high and busy low.
//   Result channel: out_valid is high for exactly one cycle per request and
//   out_item (ok, read_data, free_space) is valid in that cycle. The
//   receiver cannot stall; it must take the result when out_valid is high.
//   Config: cfg_we with cfg_data writes the ring size (clamped to 2..DEPTH,
//   at most 511) and empties the ring; stored bytes are kept. Write only when idle.
// Latency and throughput:
//   Byte requests and control requests: result in the cycle after accept;
//   a new request can be taken in the result cycle, so one per cycle.
//   Word requests (write16, read16, peek16) that are not refused: two
//   accesses to the single port of the byte store, so the result follows
//   the second access state (S_WR2 or S_RD2); busy is high there, so no new request is taken until the result cycle.
// Reset (rst_n low, synchronous): ring empty, both indices zero, size 256 (clamped to DEPTH).
//   The store itself is not cleared, so no clearing pass is needed.
// Store accesses are serialized on one port, and a read always comes in a
// later cycle than the write it depends on, so no forwarding exists.
module byte_ring_fifo_8_16_core #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  brf_pkg::in_t               in_item,
  output logic                       out_valid,
  output brf_pkg::out_t              out_item,
  input  logic                       cfg_we,
  input  logic [brf_pkg::SIZE_W-1:0] cfg_data
);
  import brf_pkg::*;

  // the 9-bit size register caps the ring at 511 slots
  localparam int SMAX = (DEPTH < 511) ? DEPTH : 511;
  localparam int SW   = $clog2(SMAX + 1);   // holds the ring size itself
  localparam int IW   = $clog2(SMAX);       // slot index

  typedef enum logic [1:0] {S_IDLE, S_WR2, S_RD2, S_RESP} state_t;
  typedef enum logic [1:0] {RS_NONE, RS_BYTE, RS_WORD} sel_t;

  state_t          state_r, state_nxt;
  sel_t            rsel_r, rsel_nxt;
  logic            ok_r, ok_nxt;
  logic [SW-1:0]   size_r;
  logic [IW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]   wr_idx_r, wr_idx_nxt;
  logic            lww_r, lww_nxt;          // last operation was a write

  logic [BYTE_W-1:0] data_lo_r, data_lo_nxt; // low byte of a pending write16
  logic [IW-1:0]     addr2_r, addr2_nxt;     // second slot of a word read
  logic              pop_r, pop_nxt;         // word read advances the ring
  logic [BYTE_W-1:0] hi_r, hi_nxt;           // high byte of a word read

  logic              mem_en, mem_we;
  logic [IW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  logic              accept;
  logic [SW-1:0]     free_c;
  logic [DATA_W-1:0] rd_data_c;

  function automatic logic [SW-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    if (v < SIZE_W'(2)) begin
      return SW'(2);
    end else if (int'(v) > SMAX) begin
      return SW'(SMAX);
    end
    return SW'(v);
  endfunction

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i,
                                             input logic [SW-1:0] s);
    logic [SW-1:0] inc;
    inc = SW'(i) + SW'(1);
    return (inc == s) ? '0 : IW'(inc);
  endfunction

  brf_ram #(
    .ENTRIES(SMAX),
    .ADDR_W (IW)
  ) u_ram (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // free slots from the current indices; equal indices resolved by the flag
  always_comb begin
    if (rd_idx_r != wr_idx_r) begin
      if (rd_idx_r > wr_idx_r) begin
        free_c = SW'(rd_idx_r) - SW'(wr_idx_r);
      end else begin
        free_c = size_r - SW'(wr_idx_r) + SW'(rd_idx_r);
      end
    end else begin
      free_c = lww_r ? '0 : size_r;
    end
  end

  // a new transaction may enter in the cycle its predecessor's result shows
  assign busy   = !(state_r == S_IDLE || state_r == S_RESP);
  assign accept = start && !busy;

  always_comb begin
    state_nxt   = state_r;
    rsel_nxt    = rsel_r;
    ok_nxt      = ok_r;
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    lww_nxt     = lww_r;
    data_lo_nxt = data_lo_r;
    addr2_nxt   = addr2_r;
    pop_nxt     = pop_r;
    hi_nxt      = hi_r;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = rd_idx_r;
    mem_wdata   = '0;

    unique case (state_r)
      S_WR2: begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = wr_idx_r;
        mem_wdata  = data_lo_r;
        wr_idx_nxt = next_idx(wr_idx_r, size_r);
        state_nxt  = S_RESP;
      end
      S_RD2: begin
        mem_en   = 1'b1;
        mem_addr = addr2_r;
        hi_nxt   = mem_rdata;
        if (pop_r) begin
          rd_idx_nxt = next_idx(addr2_r, size_r);
          lww_nxt    = 1'b0;
        end
        state_nxt = S_RESP;
      end
      S_RESP:  state_nxt = S_IDLE;
      default: ;
    endcase

    if (accept) begin
      ok_nxt    = 1'b0;
      rsel_nxt  = RS_NONE;
      state_nxt = S_RESP;
      unique case (in_item.func)
        FN_WRITE8: begin
          if (free_c != '0) begin
            mem_en     = 1'b1;
            mem_we     = 1'b1;
            mem_addr   = wr_idx_r;
            mem_wdata  = in_item.data[BYTE_W-1:0];
            wr_idx_nxt = next_idx(wr_idx_r, size_r);
            lww_nxt    = 1'b1;
            ok_nxt     = 1'b1;
          end
        end
        FN_WRITE16: begin
          if (free_c >= SW'(2)) begin
            mem_en      = 1'b1;
            mem_we      = 1'b1;
            mem_addr    = wr_idx_r;
            mem_wdata   = in_item.data[DATA_W-1:BYTE_W];
            data_lo_nxt = in_item.data[BYTE_W-1:0];
            wr_idx_nxt  = next_idx(wr_idx_r, size_r);
            lww_nxt     = 1'b1;
            ok_nxt      = 1'b1;
            state_nxt   = S_WR2;
          end
        end
        FN_READ8, FN_PEEK8: begin
          if (free_c != size_r) begin
            mem_en   = 1'b1;
            mem_addr = rd_idx_r;
            rsel_nxt = RS_BYTE;
            ok_nxt   = 1'b1;
            if (in_item.func == FN_READ8) begin
              rd_idx_nxt = next_idx(rd_idx_r, size_r);
              lww_nxt    = 1'b0;
            end
          end
        end
        FN_READ16, FN_PEEK16: begin
          // at least two stored bytes
          if (free_c < size_r - SW'(1)) begin
            mem_en    = 1'b1;
            mem_addr  = rd_idx_r;
            addr2_nxt = next_idx(rd_idx_r, size_r);
            pop_nxt   = (in_item.func == FN_READ16);
            rsel_nxt  = RS_WORD;
            ok_nxt    = 1'b1;
            state_nxt = S_RD2;
          end
        end
        FN_GOTO: begin
          if (free_c != size_r) begin
            rd_idx_nxt = (wr_idx_r == '0) ? IW'(size_r - SW'(1))
                                          : wr_idx_r - IW'(1);
            ok_nxt     = 1'b1;
          end
        end
        FN_CLEAR: begin
          // step back to the last byte, then drop it: read meets write
          if (free_c != size_r) begin
            rd_idx_nxt = wr_idx_r;
            lww_nxt    = 1'b0;
          end
          ok_nxt = 1'b1;
        end
        FN_FREE: ok_nxt = 1'b1;
        default: ;
      endcase
    end

    if (cfg_we) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      lww_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rsel_r   <= RS_NONE;
      ok_r     <= 1'b0;
      size_r   <= clamp_size(SIZE_RESET);
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      lww_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rsel_r   <= rsel_nxt;
      ok_r     <= ok_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      lww_r    <= lww_nxt;
      if (cfg_we) begin
        size_r <= clamp_size(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    data_lo_r <= data_lo_nxt;
    addr2_r   <= addr2_nxt;
    pop_r     <= pop_nxt;
    hi_r      <= hi_nxt;
  end

  // result: read data comes from the store's output register, a word's high byte from hi_r
  always_comb begin
    unique case (rsel_r)
      RS_BYTE: rd_data_c = {{(DATA_W-BYTE_W){1'b0}}, mem_rdata};
      RS_WORD: rd_data_c = {hi_r, mem_rdata};
      default: rd_data_c = '0;
    endcase
  end

  assign out_valid = (state_r == S_RESP);
  assign out_item  = {ok_r, rd_data_c, SIZE_W'(free_c)};

  // indices never leave the ring
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(rd_idx_r) < size_r) && (SW'(wr_idx_r) < size_r))
    else $error("ring index beyond ring size");

  // second half of a word access always completes next cycle
  a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR2 || state_r == S_RD2) |=> (state_r == S_RESP))
    else $error("word access did not complete");

  // after a word read's second access the result still selects the word and reports ok
  a_word_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD2) |=> (rsel_r == RS_WORD) && ok_r)
    else $error("word read lost its result selection");

  // free count reported with a result never exceeds the ring size
  a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (free_c <= size_r))
    else $error("free count above ring size");

endmodule

// File: src/brf_ram.sv
// brf_ram: single-port byte store, synchronous read with a registered output.
// Depends on brf_pkg for the byte width.
module brf_ram #(
  parameter int ENTRIES = 256,
  parameter int ADDR_W  = 8
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [brf_pkg::BYTE_W-1:0] wdata,
  output logic [brf_pkg::BYTE_W-1:0] rdata
);
  import brf_pkg::*;

  logic [BYTE_W-1:0] store_r [ENTRIES];
  logic [BYTE_W-1:0] rdata_r;

  // read data holds until the next read access
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        store_r[addr] <= wdata;
      end else begin
        rdata_r <= store_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: tb/tb_byte_ring_fifo_8_16_core.sv
// Testbench for byte_ring_fifo_8_16_core: self-checking, with a ring predictor in a scoreboard.
// Depends on brf_pkg (types, request codes) and the RTL of the core; reads no files.
module tb_byte_ring_fifo_8_16_core;
  import brf_pkg::*;

  // Codes the block refuses; random stimulus draws from this range.
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

  // Ring settings for the random phases, with the transaction count of each.
  // Slot 8 gets a random 9-bit value at run time.
  localparam int N_PHASES = 10;

  // slot index width of the predictor's store
  localparam int SB_AW = $clog2(DEPTH_DEF);

  // ------------------------------------------------------------------
  // Scoreboard: own copy of ring state, predicts one reply per request,
  // holds the replies in arrival order and compares them field by field.
  // ------------------------------------------------------------------
  class ring_scoreboard;
    logic [BYTE_W-1:0] store_mem [DEPTH_DEF];
    logic [SIZE_W-1:0] size_reg;
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    bit                was_write;
    out_t              replies [$];
    int                errors;

    function new();
      size_reg  = SIZE_RESET;
      rd_ptr    = 0;
      wr_ptr    = 0;
      was_write = 1'b0;
      errors    = 0;
    endfunction

    // size write empties the ring, store contents stay
    function void set_size(logic [SIZE_W-1:0] v);
      size_reg  = v;
      rd_ptr    = 0;
      wr_ptr    = 0;
      was_write = 1'b0;
    endfunction

    function int unsigned ring_len();
      if (size_reg < 2) return 2;
      if (size_reg > DEPTH_DEF) return DEPTH_DEF;
      return size_reg;
    endfunction

    function int unsigned free_count(int unsigned s);
      if (rd_ptr != wr_ptr) begin
        if (rd_ptr > wr_ptr) return rd_ptr - wr_ptr;
        return (s - wr_ptr) + rd_ptr;
      end
      return was_write ? 0 : s;
    endfunction

    function int unsigned advance(int unsigned i, int unsigned s);
      return (i + 1 >= s) ? 0 : i + 1;
    endfunction

    // read pointer to the slot before the write pointer
    function void jump_to_last(int unsigned s);
      rd_ptr = (wr_ptr == 0) ? s - 1 : wr_ptr - 1;
    endfunction

    function out_t apply_request(in_t req);
      int unsigned s;
      int unsigned fr;
      int unsigned nxt;
      out_t r;
      s = ring_len();
      fr = free_count(s);
      r = '0;
      case (req.func)
        FN_WRITE8: begin
          if (fr >= 1) begin
            store_mem[SB_AW'(wr_ptr)] = req.data[7:0];
            wr_ptr = advance(wr_ptr, s);
            was_write = 1'b1;
            r.ok = 1'b1;
          end
        end
        FN_WRITE16: begin
          if (fr >= 2) begin
            store_mem[SB_AW'(wr_ptr)] = req.data[15:8];
            wr_ptr = advance(wr_ptr, s);
            store_mem[SB_AW'(wr_ptr)] = req.data[7:0];
            wr_ptr = advance(wr_ptr, s);
            was_write = 1'b1;
            r.ok = 1'b1;
          end
        end
        FN_READ8, FN_PEEK8: begin
          if (fr < s) begin
            r.read_data = {8'h00, store_mem[SB_AW'(rd_ptr)]};
            if (req.func == FN_READ8) begin
              rd_ptr = advance(rd_ptr, s);
              was_write = 1'b0;
            end
            r.ok = 1'b1;
          end
        end
        FN_READ16, FN_PEEK16: begin
          if (fr + 1 < s) begin
            nxt = advance(rd_ptr, s);
            r.read_data = {store_mem[SB_AW'(rd_ptr)], store_mem[SB_AW'(nxt)]};
            if (req.func == FN_READ16) begin
              rd_ptr = advance(nxt, s);
              was_write = 1'b0;
            end
            r.ok = 1'b1;
          end
        end
        FN_GOTO: begin
          if (fr != s) begin
            jump_to_last(s);
            r.ok = 1'b1;
          end
        end
        FN_CLEAR: begin
          if (fr != s) begin
            jump_to_last(s);
            rd_ptr = advance(rd_ptr, s);
            was_write = 1'b0;
          end
          r.ok = 1'b1;
        end
        FN_FREE: r.ok = 1'b1;
        default: ;
      endcase
      r.free_space = SIZE_W'(free_count(s));
      return r;
    endfunction

    function void note_request(in_t req);
      replies.push_back(apply_request(req));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (replies.size() == 0) begin
        errors++;
        $error("reply with no request outstanding: ok=%0d read_data=%h free_space=%0d",
               got.ok, got.read_data, got.free_space);
        return;
      end
      want = replies.pop_front();
      if (got.ok !== want.ok) begin
        errors++;
        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
      end
      if (got.read_data !== want.read_data) begin
        errors++;
        $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
      end
      if (got.free_space !== want.free_space) begin
        errors++;
        $error("free_space: expected %0d, actual %0d", want.free_space, got.free_space);
      end
    endfunction
  endclass

  // ------------------------------------------------------------------
  // DUT hookup
  // ------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_t               in_item;
  logic              out_valid;
  out_t              out_item;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_data;

  ring_scoreboard    ring;
  int                burst_left;
  logic [SIZE_W-1:0] phase_size [N_PHASES];
  int                phase_len  [N_PHASES];

  byte_ring_fifo_8_16_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: the block cannot be stalled, so every strobe is taken.
  // Values are sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid) ring.check_result(out_item);
  end

  // Present one transaction and hold it until start && !busy at an edge.
  // Returns at the accepting edge; start is left high for the caller.
  task automatic issue(input in_t req);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    ring.note_request(req);
  endtask

  // Sender works in bursts; between bursts start drops for a random gap,
  // so gaps land on both byte and word transactions at any phase.
  task automatic send(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] d);
    in_t req;
    req.func = f;
    req.data = d;
    issue(req);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Size register is written only with nothing in flight; the extra
  // cycles cover the second store access of word transactions.
  task automatic set_ring_size(input logic [SIZE_W-1:0] v);
    start <= 1'b0;
    while (ring.replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring.set_size(v);
  endtask

  // Directed opening: empty-ring refusals, data extremes, every request
  // code, goto and clear on empty and non-empty rings, then a 3-slot ring
  // for a full-ring byte refusal, one-free and one-stored word refusals and a wrap.
  task automatic run_directed();
    send(FN_FREE,      16'h0000);
    send(FN_READ8,     16'h0000);   // empty: refused
    send(FN_PEEK16,    16'h0000);
    send(FN_GOTO,      16'h0000);   // empty: refused
    send(FN_CLEAR,     16'h0000);   // empty: still ok
    send(FN_WRITE8,    16'hFFFF);   // only the low byte is stored
    send(FN_WRITE16,   16'h0000);
    send(FN_WRITE16,   16'hFFFF);
    send(FN_PEEK8,     16'h0000);
    send(FN_PEEK16,    16'h0000);
    send(FN_READ16,    16'h0000);
    send(FN_UNUSED_LO, 16'hFFFF);
    send(FN_UNUSED_HI, 16'h0000);
    send(FN_WRITE8,    16'h005A);
    send(FN_GOTO,      16'h0000);   // non-empty: one byte left
    send(FN_READ8,     16'h0000);
    send(FN_WRITE8,    16'h0011);
    send(FN_CLEAR,     16'h0000);   // non-empty: drops to empty
    send(FN_FREE,      16'h0000);
    set_ring_size(9'd3);
    send(FN_WRITE16,   16'hA55A);
    send(FN_WRITE16,   16'h1234);   // one free slot: refused
    send(FN_WRITE8,    16'h00C3);
    send(FN_WRITE8,    16'h0077);   // full: refused
    send(FN_READ16,    16'h0000);
    send(FN_PEEK16,    16'h0000);   // one byte stored: refused
    send(FN_READ8,     16'h0000);
  endtask

  // Random phase: alternating fill and drain stretches so the ring reaches
  // both full and empty. Goto and clear stay out of fill stretches since
  // either one collapses the ring to at most one byte.
  task automatic run_mixed(input int n);
    int unsigned s;
    int unsigned pick;
    int unsigned run_left;
    bit          filling;
    logic [FUNC_W-1:0] f;
    logic [DATA_W-1:0] d;
    s = ring.ring_len();
    filling = 1'b0;
    run_left = 0;
    repeat (n) begin
      if (run_left == 0) begin
        filling = !filling;
        if (s > 64) run_left = filling ? 360 : 60;
        else run_left = $urandom_range(3, 2 * s + 6);
      end
      run_left--;
      pick = $urandom_range(0, 99);
      if (filling) begin
        if (pick < 30)      f = FN_WRITE8;
        else if (pick < 65) f = FN_WRITE16;
        else if (pick < 74) f = FN_READ8;
        else if (pick < 79) f = FN_READ16;
        else if (pick < 84) f = FN_PEEK8;
        else if (pick < 89) f = FN_PEEK16;
        else if (pick < 94) f = FN_FREE;
        else                f = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      end else begin
        if (pick < 12)      f = FN_WRITE8;
        else if (pick < 20) f = FN_WRITE16;
        else if (pick < 40) f = FN_READ8;
        else if (pick < 60) f = FN_READ16;
        else if (pick < 68) f = FN_PEEK8;
        else if (pick < 76) f = FN_PEEK16;
        else if (pick < 83) f = FN_GOTO;
        else if (pick < 88) f = FN_CLEAR;
        else if (pick < 94) f = FN_FREE;
        else                f = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      end
      case ($urandom_range(0, 7))
        0:       d = 16'h0000;
        1:       d = 16'hFFFF;
        default: d = DATA_W'($urandom);
      endcase
      send(f, d);
    end
  endtask

  initial begin
    ring = new();
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_item  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    burst_left = $urandom_range(0, 24);
    // below-range, tiny, mid, beyond-range and full-depth sizes
    phase_size = '{9'd2, 9'd0, 9'd1, 9'd3, 9'd7, 9'd16, 9'd511, 9'd255, 9'd0, 9'd256};
    phase_len  = '{90, 50, 50, 90, 90, 110, 400, 330, 90, 150};
    phase_size[8] = SIZE_W'($urandom_range(0, 511));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // the directed opening runs at the reset size, no register write ahead of it
    run_directed();
    for (int p = 0; p < N_PHASES; p++) begin
      set_ring_size(phase_size[p]);
      run_mixed(phase_len[p]);
    end

    // drain: every reply in, then a few cycles to catch stray strobes
    start <= 1'b0;
    while (ring.replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (ring.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
